// File: rtl/l2vn_pkg.sv
// ----------------------------------------------------------------------------
// l2vn_pkg
// shared constants and types of the l2 vector normalizer
// ----------------------------------------------------------------------------
`default_nettype none

package l2vn_pkg;

    localparam int DEF_MAX_VECTOR_LENGTH = 64;
    localparam int DEF_SAMPLE_WIDTH      = 16;

    localparam int             CFG_W      = 7;
    localparam logic [CFG_W-1:0] VL_RESET = 7'd64;

    // inverse norm is unsigned q1.31, root of the quotient of 2^62 by the square sum
    localparam int INV_W  = 32;
    localparam int QUOT_W = 2 * INV_W - 1;

    // ping-pong element buffer, one queued job per bank
    localparam int NUM_BANKS = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/l2vn_queue.sv
// ----------------------------------------------------------------------------
// l2vn_queue
// small job queue between the front and back of the normalizer
// ----------------------------------------------------------------------------
`default_nettype none

module l2vn_queue
    import l2vn_pkg::*;
#(
    parameter int W = 45
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wr_data,
    input  wire logic         pop,
    output q_stat_t           stat,
    output logic [W-1:0]      rd_data
);

    localparam int PW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int CW = $clog2(NUM_BANKS + 1);

    logic [W-1:0]  entry_reg [NUM_BANKS];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(NUM_BANKS - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(NUM_BANKS - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign stat.full  = (cnt_reg == CW'(NUM_BANKS));
    assign stat.empty = (cnt_reg == '0);
    assign rd_data    = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: rtl/l2vn_front.sv
// ----------------------------------------------------------------------------
// l2vn_front
// accepts sample beats, buffers them and sums their squares per vector
// ----------------------------------------------------------------------------
`default_nettype none

module l2vn_front
    import l2vn_pkg::*;
#(
    parameter int MAX_VECTOR_LENGTH = DEF_MAX_VECTOR_LENGTH,
    parameter int SAMPLE_WIDTH      = DEF_SAMPLE_WIDTH,
    localparam int AW    = $clog2(MAX_VECTOR_LENGTH),
    localparam int CNT_W = $clog2(MAX_VECTOR_LENGTH + 1),
    localparam int SUM_W = 2 * SAMPLE_WIDTH - 1 + AW,
    localparam int JOB_W = 1 + CNT_W + SUM_W,
    localparam int TD_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_W-1:0]        cfg_wr_data,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [TD_W-1:0]         s_axis_tdata,
    input  wire q_stat_t                 q_stat,
    output logic                         q_push,
    output logic [JOB_W-1:0]             q_wr_data,
    output logic                         mem_wr_en,
    output logic [AW:0]                  mem_wr_addr,
    output logic [SAMPLE_WIDTH-1:0]      mem_wr_data
);

    localparam int LW = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_VECTOR_LENGTH);

    logic [CFG_W-1:0] vl_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             bank_reg, bank_next;

    logic                            accept;
    logic signed [SAMPLE_WIDTH-1:0]  smp;
    logic signed [2*SAMPLE_WIDTH-1:0] sq_full;
    logic [LW-1:0]                   vl_ext;
    logic [LW-1:0]                   eff_len;
    logic [CNT_W-1:0]                count_inc;
    logic [SUM_W-1:0]                sum_inc;
    logic                            complete;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign smp           = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign sq_full       = smp * smp;
    assign count_inc     = CNT_W'(count_reg + 1'b1);
    assign sum_inc       = sum_reg + SUM_W'(sq_full[2*SAMPLE_WIDTH-2:0]);

    // zero acts as one, anything above the buffer depth as the depth
    assign vl_ext  = LW'(vl_reg);
    assign eff_len = (vl_reg == '0) ? LW'(1) : ((vl_ext > MAX_L) ? MAX_L : vl_ext);
    assign complete = (LW'(count_inc) >= eff_len);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (complete)
            begin
                count_next = '0;
                sum_next   = '0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = count_inc;
                sum_next   = sum_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg    <= VL_RESET;
            count_reg <= '0;
            sum_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vl_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            sum_reg   <= sum_next;
            bank_reg  <= bank_next;
        end
    end

    assign mem_wr_en   = accept;
    assign mem_wr_addr = {bank_reg, count_reg[AW-1:0]};
    assign mem_wr_data = smp;

    assign q_push    = accept && complete;
    assign q_wr_data = {bank_reg, count_inc, sum_inc};

endmodule

`default_nettype wire

// File: rtl/l2vn_back.sv
// ----------------------------------------------------------------------------
// l2vn_back
// inverse norm by serial divide and square root, then scales each element
// ----------------------------------------------------------------------------
`default_nettype none

module l2vn_back
    import l2vn_pkg::*;
#(
    parameter int MAX_VECTOR_LENGTH = DEF_MAX_VECTOR_LENGTH,
    parameter int SAMPLE_WIDTH      = DEF_SAMPLE_WIDTH,
    localparam int AW    = $clog2(MAX_VECTOR_LENGTH),
    localparam int CNT_W = $clog2(MAX_VECTOR_LENGTH + 1),
    localparam int SUM_W = 2 * SAMPLE_WIDTH - 1 + AW,
    localparam int JOB_W = 1 + CNT_W + SUM_W,
    localparam int TD_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    mem_wr_en,
    input  wire logic [AW:0]             mem_wr_addr,
    input  wire logic [SAMPLE_WIDTH-1:0] mem_wr_data,
    input  wire q_stat_t                 q_stat,
    input  wire logic [JOB_W-1:0]        q_rd_data,
    output logic                         q_pop,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [TD_W-1:0]              m_axis_tdata,
    output logic                         m_axis_tlast,
    output logic                         m_axis_tuser
);

    localparam int SW        = SAMPLE_WIDTH;
    localparam int PROD_W    = SW + INV_W;
    localparam int OUT_SHIFT = INV_W - SW;
    localparam int STEP_W    = $clog2(QUOT_W);
    localparam logic [STEP_W-1:0] DIV_TOP  = STEP_W'(QUOT_W - 1);
    localparam logic [STEP_W-1:0] SQRT_TOP = STEP_W'(QUOT_W / 2);
    localparam logic [QUOT_W-1:0] BIT_TOP  = QUOT_W'(1) << (QUOT_W - 1);
    localparam logic [PROD_W:0] HALF =
        (OUT_SHIFT > 0) ? ((PROD_W+1)'(1) << (OUT_SHIFT > 0 ? OUT_SHIFT - 1 : 0)) : '0;
    localparam logic [PROD_W:0] LIM  = (PROD_W+1)'(1) << (SW - 1);
    localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              s1_valid_reg, s2_valid_reg, out_valid_reg;

    logic              bank_reg, bank_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [SUM_W-1:0]  div_reg, div_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] v_reg, v_next;
    logic [QUOT_W-1:0] r_reg, r_next;
    logic [QUOT_W-1:0] bit_reg, bit_next;
    logic [INV_W-1:0]  inv_reg, inv_next;
    logic              zero_reg, zero_next;

    logic [SW-1:0]     mem [NUM_BANKS * (2**AW)];
    logic [SW-1:0]     rd_data_reg;
    logic              s1_last_reg;
    logic              s2_last_reg, s2_neg_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [SW-1:0]     out_data_reg;
    logic              out_last_reg, out_zero_reg;

    logic              job_bank;
    logic [CNT_W-1:0]  job_cnt;
    logic [SUM_W-1:0]  job_sum;

    logic [SUM_W:0]    shifted, diff;
    logic              div_ge;
    logic [QUOT_W-1:0] sq_t;
    logic              sq_ge;
    logic [QUOT_W-1:0] sq_v, sq_r;

    logic              adv, issue, done;
    logic [AW:0]       rd_addr;
    logic [SW-1:0]     mag;
    logic [PROD_W:0]   rnd;
    logic              big;
    logic [SW-1:0]     res;

    assign job_bank = q_rd_data[JOB_W-1];
    assign job_cnt  = q_rd_data[SUM_W +: CNT_W];
    assign job_sum  = q_rd_data[SUM_W-1:0];

    // restoring divide of 2^62 by the square sum, one quotient bit per step
    assign shifted = {rem_reg, (step_reg == DIV_TOP)};
    assign div_ge  = (shifted >= {1'b0, div_reg});
    assign diff    = shifted - {1'b0, div_reg};

    // digit-by-digit square root of the quotient, one result bit per step
    assign sq_t  = r_reg + bit_reg;
    assign sq_ge = (v_reg >= sq_t);
    assign sq_v  = sq_ge ? (v_reg - sq_t) : v_reg;
    assign sq_r  = sq_ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);

    assign adv     = !out_valid_reg || m_axis_tready;
    assign issue   = (state_reg == ST_EMIT) && adv && (k_reg < n_reg);
    assign done    = (state_reg == ST_EMIT) && (k_reg == n_reg)
                     && !s1_valid_reg && !s2_valid_reg;
    assign rd_addr = {bank_reg, k_reg[AW-1:0]};
    assign q_pop   = done;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        bank_next  = bank_reg;
        n_next     = n_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        inv_next   = inv_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    bank_next = job_bank;
                    n_next    = job_cnt;
                    div_next  = job_sum;
                    k_next    = '0;
                    if (job_sum == '0)
                    begin
                        inv_next   = '0;
                        zero_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        rem_next   = '0;
                        v_next     = '0;
                        step_next  = DIV_TOP;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
                v_next   = {v_reg[QUOT_W-2:0], div_ge};
                if (step_reg == '0)
                begin
                    r_next     = '0;
                    bit_next   = BIT_TOP;
                    step_next  = SQRT_TOP;
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = STEP_W'(step_reg - 1'b1);
                end
            end
            ST_SQRT:
            begin
                v_next   = sq_v;
                r_next   = sq_r;
                bit_next = bit_reg >> 2;
                if (step_reg == '0)
                begin
                    inv_next   = sq_r[INV_W-1:0];
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = STEP_W'(step_reg - 1'b1);
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    k_next = CNT_W'(k_reg + 1'b1);
                end
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        n_reg    <= n_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        inv_reg  <= inv_next;
        zero_reg <= zero_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (adv)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // magnitude of the most negative sample still fits unsigned
    assign mag = rd_data_reg[SW-1] ? SW'(~rd_data_reg + 1'b1) : rd_data_reg;

    assign rnd = ({1'b0, s2_prod_reg} + HALF) >> OUT_SHIFT;
    assign big = (rnd >= LIM);

    always_comb
    begin
        if (s2_neg_reg)
        begin
            res = big ? SMP_MIN : SW'(~rnd[SW-1:0] + 1'b1);
        end
        else
        begin
            res = big ? SMP_MAX : rnd[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_last_reg  <= (CNT_W'(k_reg + 1'b1) == n_reg);
            s2_last_reg  <= s1_last_reg;
            s2_neg_reg   <= rd_data_reg[SW-1];
            s2_prod_reg  <= mag * inv_reg;
            out_data_reg <= res;
            out_last_reg <= s2_last_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TD_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_zero_reg;

endmodule

`default_nettype wire

// File: rtl/l2_vector_normalizer_top.sv
// ----------------------------------------------------------------------------
// l2_vector_normalizer_top
// a vector's first result waits on the back end: 63-step divide, 32-step square
// root, and the read, multiply and saturate pipeline
// throughput: one sample beat per cycle in while the queue has room, one result
// beat per cycle out while the sink is ready; new vectors are taken in meanwhile
// reset: asynchronous, clears counters, queue and pipeline; length resets to 64
// ----------------------------------------------------------------------------
`default_nettype none

module l2_vector_normalizer_top
    import l2vn_pkg::*;
#(
    parameter int MAX_VECTOR_LENGTH = DEF_MAX_VECTOR_LENGTH,
    parameter int SAMPLE_WIDTH      = DEF_SAMPLE_WIDTH,
    localparam int TD_W = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,   // vector_length
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [TD_W-1:0]  s_axis_tdata,  // sample
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [TD_W-1:0]       m_axis_tdata,  // normalized_sample
    output logic                  m_axis_tlast,  // last_of_vector
    output logic                  m_axis_tuser   // zero_vector
);

    localparam int AW    = $clog2(MAX_VECTOR_LENGTH);
    localparam int CNT_W = $clog2(MAX_VECTOR_LENGTH + 1);
    localparam int SUM_W = 2 * SAMPLE_WIDTH - 1 + AW;
    localparam int JOB_W = 1 + CNT_W + SUM_W;

    q_stat_t                 q_stat;
    logic                    q_push;
    logic                    q_pop;
    logic [JOB_W-1:0]        q_wr_data;
    logic [JOB_W-1:0]        q_rd_data;
    logic                    mem_wr_en;
    logic [AW:0]             mem_wr_addr;
    logic [SAMPLE_WIDTH-1:0] mem_wr_data;

    l2vn_front #(
        .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
        .SAMPLE_WIDTH      (SAMPLE_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_wr_data     (q_wr_data),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data)
    );

    l2vn_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    l2vn_back #(
        .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
        .SAMPLE_WIDTH      (SAMPLE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .q_stat        (q_stat),
        .q_rd_data     (q_rd_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero vector beat with nonzero data");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for l2_vector_normalizer_top: directed corner vectors,
// then random vectors of random length with random stalls on both streams;
// every result beat is compared against a behavioral normalizer model
// ----------------------------------------------------------------------------

module tb;
    import l2vn_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int SW           = 16;
    localparam int ITEM_TARGET  = 355;
    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 600;

    localparam logic [SW-1:0] POS_FULL = 16'h7FFF;
    localparam logic [SW-1:0] NEG_FULL = 16'h8000;

    typedef enum {FILL_ZERO, FILL_EXTREME, FILL_TINY, FILL_SPARSE, FILL_RANDOM} fill_t;

    typedef struct {
        logic [SW-1:0] value;
        logic          last;
        logic          zero;
    } norm_beat_t;

    class norm_scoreboard;
        logic signed [SW-1:0] elem_buf[MAX_LEN];
        logic [36:0]          sq_sum;
        int                   elem_cnt;
        logic [CFG_W-1:0]     vec_len;
        norm_beat_t           expected_q[$];
        int                   mismatches;

        function new();
            sq_sum     = '0;
            elem_cnt   = 0;
            vec_len    = VL_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            int b;
            root = 0;
            for (b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        // magnitude times q1.31 inverse norm, rounded half away, sign after
        function logic [SW-1:0] scale(logic signed [SW-1:0] x, logic [31:0] inv);
            longint          sx;
            longint unsigned mag;
            longint unsigned prod;
            longint          res;
            sx   = x;
            mag  = (sx < 0) ? -sx : sx;
            prod = (mag * inv + 64'd32768) >> 16;
            if (prod > 64'd32768)
                prod = 64'd32768;
            res = (sx < 0) ? -longint'(prod) : longint'(prod);
            if (res > 32767)
                res = 32767;
            return res[SW-1:0];
        endfunction

        function void note_sample(logic signed [SW-1:0] x);
            int          eff;
            int          k;
            longint      sx;
            logic [31:0] inv;
            logic        zero;
            norm_beat_t  beat;
            if (elem_cnt >= MAX_LEN)
                elem_cnt = 0;
            elem_buf[elem_cnt] = x;
            sx = x;
            sq_sum += 37'(sx * sx);
            elem_cnt++;
            eff = (vec_len == 0) ? 1 : (int'(vec_len) > MAX_LEN) ? MAX_LEN : int'(vec_len);
            if (elem_cnt < eff)
                return;
            zero = (sq_sum == 0);
            inv  = zero ? 32'd0 : 32'(int_sqrt((64'd1 << 62) / 64'(sq_sum)));
            for (k = 0; k < elem_cnt; k++)
            begin
                beat.value = zero ? '0 : scale(elem_buf[k], inv);
                beat.last  = (k == elem_cnt - 1);
                beat.zero  = zero;
                expected_q.push_back(beat);
            end
            elem_cnt = 0;
            sq_sum   = '0;
        endfunction

        function void check_beat(logic [SW-1:0] value, logic last, logic zero);
            norm_beat_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: data=%h last=%b zero=%b", value, last, zero);
                return;
            end
            want = expected_q.pop_front();
            if (want.value !== value || want.last !== last || want.zero !== zero)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected data=%h last=%b zero=%b, got data=%h last=%b zero=%b",
                             want.value, want.last, want.zero, value, last, zero);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [SW-1:0]     s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [SW-1:0]     m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    norm_scoreboard scb;
    bit             calm;
    int             hold_req;
    int             items_sent;

    l2_vector_normalizer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SW-1:0] gen_sample(fill_t fill);
        logic [SW-1:0] v;
        case (fill)
            FILL_ZERO:
                v = '0;
            FILL_EXTREME:
                case ($urandom_range(0, 4))
                    0:       v = POS_FULL;
                    1:       v = NEG_FULL;
                    2:       v = '0;
                    3:       v = 16'h0001;
                    default: v = 16'hFFFF;
                endcase
            FILL_TINY:
            begin
                v = SW'($urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            FILL_SPARSE:
                v = ($urandom_range(0, 7) == 0) ? SW'($urandom) : '0;
            default:
                v = SW'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic [SW-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scb.note_sample(x);
        items_sent++;
    endtask

    // sends until the open vector closes, a whole one if none is open
    task automatic send_vector(input fill_t fill);
        do
            send_sample(gen_sample(fill));
        while (scb.elem_cnt != 0);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (scb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] len);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        scb.vec_len = len;
    endtask

    initial
    begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                scb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        int    r;
        int    len;
        int    nvec;
        fill_t fill;
        scb        = new();
        calm       = 1'b0;
        hold_req   = 0;
        items_sent = 0;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale extremes in one vector
        write_length(7'd4);
        send_sample(POS_FULL);
        send_sample(NEG_FULL);
        send_sample(16'h0000);
        send_sample(16'h0001);

        // all-zero vector
        write_length(7'd3);
        repeat (3) send_sample(16'h0000);

        // single-element vectors, positive full scale saturates
        write_length(7'd1);
        send_sample(NEG_FULL);
        send_sample(POS_FULL);
        send_sample(16'h0001);
        send_sample(16'hFFFF);

        // length zero behaves as one
        write_length(7'd0);
        send_sample(16'h5555);
        send_sample(16'hAAAA);

        // length lowered below the open count
        write_length(7'd8);
        send_sample(16'd1000);
        send_sample(-16'sd2000);
        send_sample(16'd3000);
        write_length(7'd2);
        send_sample(16'h0100);

        // length lowered mid-vector, still above the open count
        write_length(7'd5);
        send_sample(16'h4000);
        send_sample(16'hC000);
        write_length(7'd3);
        send_sample(16'h0007);

        // results held off while vectors pile up behind them
        write_length(7'd16);
        calm     = 1'b1;
        hold_req = HOLD_CYCLES;
        repeat (5) send_vector(FILL_RANDOM);
        calm = 1'b0;

        // length above the maximum clamps to 64
        write_length(7'd127);
        send_vector(FILL_EXTREME);

        while (items_sent < ITEM_TARGET)
        begin
            r   = $urandom_range(0, 99);
            len = (r < 60) ? $urandom_range(1, 8) :
                  (r < 80) ? $urandom_range(9, 32) :
                  (r < 88) ? $urandom_range(33, 64) :
                  (r < 92) ? 0 : $urandom_range(65, 127);
            write_length(CFG_W'(len));
            calm = ($urandom_range(0, 3) == 0);
            nvec = $urandom_range(1, 3);
            repeat (nvec)
            begin
                r    = $urandom_range(0, 9);
                fill = (r == 0) ? FILL_ZERO :
                       (r == 1) ? FILL_EXTREME :
                       (r == 2) ? FILL_TINY :
                       (r == 3) ? FILL_SPARSE : FILL_RANDOM;
                send_vector(fill);
            end
            if ($urandom_range(0, 5) == 0 && len >= 2 && len <= MAX_LEN)
            begin
                repeat ($urandom_range(1, len - 1)) send_sample(gen_sample(FILL_RANDOM));
                write_length(CFG_W'($urandom_range(1, 12)));
                send_vector(FILL_RANDOM);
            end
        end
        calm = 1'b0;

        wait_drain();
        if (scb.mismatches == 0 && scb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
